[rtl/core/bitmap_page_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define BPA_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define BPA_ASSERT(lbl, clk, rstn, prop)
`define BPA_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[rtl/core/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, result codes and controller states.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned NumBlocksDef  = 32768;
  localparam int unsigned BlockShiftDef = 12;
  localparam int unsigned WordBitsDef   = 32;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned BaddrW  = 27;
  localparam int unsigned FreeW   = 28;
  localparam int unsigned MDataW  = 56;
  localparam int unsigned ApbAw   = 3;
  localparam int unsigned ApbDw   = 32;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  localparam logic RegBlockCount = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NONE_FREE = 2'd1,
    STATUS_BAD_FREE  = 2'd2
  } bpa_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ALLOC_WORD,
    ST_ALLOC_MARK,
    ST_FREE_MARK,
    ST_RESULT
  } bpa_state_e;

endpackage

[rtl/core/bpa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bpa_ffs.sv]
// ----------------------------------------------------------------------------
// Find first set
// Index of the lowest set bit of a vector, with a flag for any bit set.
// ----------------------------------------------------------------------------
module bpa_ffs #(
  parameter int unsigned Width = 32,
  localparam int unsigned IdxW = (Width > 1) ? $clog2(Width) : 1
) (
  input  logic [Width-1:0] vec_i,
  output logic             found_o,
  output logic [IdxW-1:0]  index_o
);

  always_comb begin
    index_o = '0;
    for (int i = Width - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        index_o = IdxW'(i);
      end
    end
  end

  assign found_o = |vec_i;

endmodule

[rtl/core/bitmap_page_allocator.sv]
// One request is in work at a time: a new word is taken only once the previous result has
// been loaded into the result register. An allocate makes two dependent reads, of the
// summary RAM and then the bitmap RAM; a free reads both at once, and early rejects none.
// Reset, and any write of block_count, marks every block used at once; no clearing pass.
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit page frame allocator over a used/free bitmap held in RAM, with a
// RAM of per-word not-full summary bits and a flop vector of non-empty
// summary words. A summary bit that is clear means its bitmap word is full,
// and a top bit that is clear means its summary word is all clear, so the RAM
// contents need no initialization. Word size must be a power of two.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_assert.svh"

module bitmap_page_allocator #(
  parameter int unsigned NumBlocks  = bpa_pkg::NumBlocksDef,
  parameter int unsigned BlockShift = bpa_pkg::BlockShiftDef,
  parameter int unsigned WordBits   = bpa_pkg::WordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::ApbAw-1:0]   paddr,
  input  logic [bpa_pkg::ApbDw-1:0]   pwdata,
  output logic [bpa_pkg::ApbDw-1:0]   prdata,
  output logic                        pready,
  // Request stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bpa_pkg::AddrW-1:0]   s_axis_tdata,  // [31:0] address
  input  logic                        s_axis_tuser,  // [0] kind
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bpa_pkg::MDataW-1:0]  m_axis_tdata,  // [26:0] block_address, [54:27] free_bytes
  output logic [1:0]                  m_axis_tuser   // [1:0] status
);

  localparam int unsigned BitW     = $clog2(WordBits);
  localparam int unsigned MapWords = (NumBlocks + WordBits - 1) / WordBits;
  localparam int unsigned MapAw    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned SumWords = (MapWords + WordBits - 1) / WordBits;
  localparam int unsigned SumAw    = (SumWords > 1) ? $clog2(SumWords) : 1;
  localparam int unsigned TopIdxW  = (SumWords > 1) ? $clog2(SumWords) : 1;
  localparam int unsigned CntW     = $clog2(NumBlocks + 1);
  localparam int unsigned BlkW     = SumAw + 2 * BitW;

  bpa_pkg::bpa_state_e  state_q, state_d;
  bpa_pkg::bpa_status_e status_q, status_d;

  logic [bpa_pkg::CfgW-1:0]   cfg_q;
  logic [CntW-1:0]            cnt_q, used_q, used_d, cnt_wr;
  logic [SumWords-1:0]        top_q, top_d;
  logic                       kind_q;
  logic [bpa_pkg::AddrW-1:0]  blk_q;
  logic [SumAw-1:0]           t_q, t_d;
  logic [BitW-1:0]            s_q, s_d;
  logic [WordBits-1:0]        sum_q, sum_d;
  logic [bpa_pkg::BaddrW-1:0] baddr_q, baddr_d;

  logic                       m_valid_q, m_valid_d, load;
  logic [1:0]                 m_status_q;
  logic [bpa_pkg::BaddrW-1:0] m_baddr_q;
  logic [bpa_pkg::FreeW-1:0]  m_free_q;

  logic                       cfg_we;
  logic                       sum_we, sum_re, map_we, map_re;
  logic [SumAw-1:0]           sum_waddr, sum_raddr;
  logic [MapAw-1:0]           map_waddr, map_raddr;
  logic [WordBits-1:0]        sum_wdata, sum_rdata, map_wdata, map_rdata;

  logic                       top_found;
  logic [TopIdxW-1:0]         top_idx;
  logic                       sum_found;
  logic [BitW-1:0]            sum_idx;
  logic                       zero_found;
  logic [BitW-1:0]            zero_idx;

  logic [WordBits-1:0]        new_map, new_sum, sum_eff, map_eff;
  logic [BitW-1:0]            free_bit;
  logic [BlkW-1:0]            alloc_blk;
  logic [63:0]                baddr_wide, free_wide;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == bpa_pkg::RegBlockCount);
  assign prdata = (paddr[2] == bpa_pkg::RegBlockCount) ? bpa_pkg::ApbDw'(cfg_q) : '0;
  assign cnt_wr = (32'(pwdata[bpa_pkg::CfgW-1:0]) > NumBlocks) ? CntW'(NumBlocks)
                                                               : CntW'(pwdata[bpa_pkg::CfgW-1:0]);

  bpa_ram #(.Width(WordBits), .Depth(SumWords)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  bpa_ram #(.Width(WordBits), .Depth(MapWords)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bpa_ffs #(.Width(SumWords)) u_top_ffs (
    .vec_i   (top_q),
    .found_o (top_found),
    .index_o (top_idx)
  );

  bpa_ffs #(.Width(WordBits)) u_sum_ffs (
    .vec_i   (sum_rdata),
    .found_o (sum_found),
    .index_o (sum_idx)
  );

  bpa_ffs #(.Width(WordBits)) u_zero_ffs (
    .vec_i   (~map_rdata),
    .found_o (zero_found),
    .index_o (zero_idx)
  );

  assign free_bit   = blk_q[BitW-1:0];
  assign sum_eff    = top_q[t_q] ? sum_rdata : '0;
  assign map_eff    = sum_eff[s_q] ? map_rdata : '1;
  assign alloc_blk  = {t_q, s_q, zero_idx};
  assign baddr_wide = 64'(alloc_blk) << BlockShift;
  assign free_wide  = 64'(cnt_q - used_q) << BlockShift;
  assign load       = (state_q == bpa_pkg::ST_RESULT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    used_d    = used_q;
    top_d     = top_q;
    t_d       = t_q;
    s_d       = s_q;
    sum_d     = sum_q;
    baddr_d   = baddr_q;
    sum_re    = 1'b0;
    sum_raddr = t_q;
    map_re    = 1'b0;
    map_raddr = MapAw'({t_q, s_q});
    sum_we    = 1'b0;
    sum_waddr = t_q;
    sum_wdata = '0;
    map_we    = 1'b0;
    map_waddr = MapAw'({t_q, s_q});
    map_wdata = '0;
    new_map   = '0;
    new_sum   = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      bpa_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = bpa_pkg::ST_LOOKUP;
        end
      end
      bpa_pkg::ST_LOOKUP: begin
        status_d = bpa_pkg::STATUS_OK;
        baddr_d  = '0;
        if (kind_q == bpa_pkg::KindAlloc) begin
          if (!top_found) begin
            status_d = bpa_pkg::STATUS_NONE_FREE;
            state_d  = bpa_pkg::ST_RESULT;
          end else begin
            t_d       = SumAw'(top_idx);
            sum_re    = 1'b1;
            sum_raddr = SumAw'(top_idx);
            state_d   = bpa_pkg::ST_ALLOC_WORD;
          end
        end else begin
          if (blk_q >= bpa_pkg::AddrW'(cnt_q)) begin
            status_d = bpa_pkg::STATUS_BAD_FREE;
            state_d  = bpa_pkg::ST_RESULT;
          end else begin
            t_d       = SumAw'(blk_q >> (2 * BitW));
            s_d       = blk_q[2*BitW-1:BitW];
            sum_re    = 1'b1;
            sum_raddr = SumAw'(blk_q >> (2 * BitW));
            map_re    = 1'b1;
            map_raddr = MapAw'(blk_q >> BitW);
            state_d   = bpa_pkg::ST_FREE_MARK;
          end
        end
      end
      bpa_pkg::ST_ALLOC_WORD: begin
        s_d       = sum_idx;
        sum_d     = sum_rdata;
        map_re    = 1'b1;
        map_raddr = MapAw'({t_q, sum_idx});
        state_d   = bpa_pkg::ST_ALLOC_MARK;
      end
      bpa_pkg::ST_ALLOC_MARK: begin
        new_map   = map_rdata | (WordBits'(1) << zero_idx);
        map_we    = 1'b1;
        map_wdata = new_map;
        if (&new_map) begin
          new_sum   = sum_q & ~(WordBits'(1) << s_q);
          sum_we    = 1'b1;
          sum_wdata = new_sum;
          if (new_sum == '0) begin
            top_d[t_q] = 1'b0;
          end
        end
        used_d  = used_q + CntW'(1);
        baddr_d = baddr_wide[bpa_pkg::BaddrW-1:0];
        state_d = bpa_pkg::ST_RESULT;
      end
      bpa_pkg::ST_FREE_MARK: begin
        if (!map_eff[free_bit] || (used_q == '0)) begin
          status_d = bpa_pkg::STATUS_BAD_FREE;
        end else begin
          map_we     = 1'b1;
          map_wdata  = map_eff & ~(WordBits'(1) << free_bit);
          sum_we     = 1'b1;
          sum_wdata  = sum_eff | (WordBits'(1) << s_q);
          top_d[t_q] = 1'b1;
          used_d     = used_q - CntW'(1);
        end
        state_d = bpa_pkg::ST_RESULT;
      end
      bpa_pkg::ST_RESULT: begin
        if (load) begin
          state_d = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_valid_d = load || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpa_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      cfg_q     <= bpa_pkg::CfgW'(NumBlocks);
      cnt_q     <= CntW'(NumBlocks);
      used_q    <= CntW'(NumBlocks);
      top_q     <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we) begin
        cfg_q  <= pwdata[bpa_pkg::CfgW-1:0];
        cnt_q  <= cnt_wr;
        used_q <= cnt_wr;
        top_q  <= '0;
      end else begin
        used_q <= used_d;
        top_q  <= top_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      blk_q  <= s_axis_tdata >> BlockShift;
    end
    status_q <= status_d;
    t_q      <= t_d;
    s_q      <= s_d;
    sum_q    <= sum_d;
    baddr_q  <= baddr_d;
    if (load) begin
      m_status_q <= status_q;
      m_baddr_q  <= baddr_q;
      m_free_q   <= free_wide[bpa_pkg::FreeW-1:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {1'b0, m_free_q, m_baddr_q};

  `BPA_ASSERT(a_used_within_count, clk_i, rst_ni, used_q <= cnt_q)
  `BPA_ASSERT(a_cfg_marks_all_used, clk_i, rst_ni, cfg_we |=> (top_q == '0))
  `BPA_ASSERT(a_none_free_means_full, clk_i, rst_ni,
              ((state_q == bpa_pkg::ST_LOOKUP) && (kind_q == bpa_pkg::KindAlloc) &&
               !top_found) |-> (used_q == cnt_q))
  `BPA_ASSERT_NEVER(a_summary_points_to_full, clk_i, rst_ni,
                    (state_q == bpa_pkg::ST_ALLOC_MARK) && !zero_found)
  `BPA_ASSERT_NEVER(a_summary_word_empty, clk_i, rst_ni,
                    (state_q == bpa_pkg::ST_ALLOC_WORD) && !sum_found)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate and free words through the request stream with random gaps
// and result-side stalls. Every accepted request is run through a first-fit
// bitmap predictor, and each result word is compared field by field against
// the oldest predicted one. The run goes through several block counts,
// including zero, one, the full size and a saturating value.
// ----------------------------------------------------------------------------
module testbench;
  import bpa_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned MaxReports    = 10;
  localparam logic [ApbAw-1:0] BlockCountAddr = {RegBlockCount, 2'b00};
  localparam logic [ApbAw-1:0] UnusedRegAddr  = 3'd4;

  typedef struct {
    bpa_status_e       status;
    logic [BaddrW-1:0] block_address;
    logic [FreeW-1:0]  free_bytes;
  } alloc_result_t;

  class alloc_scoreboard;
    bit            used_map [NumBlocksDef];
    int unsigned   used_blocks;
    logic [15:0]   block_count;
    alloc_result_t pending_results[$];
    int unsigned   errors, requests, checked;
    int unsigned   allocs_ok, none_free, frees_ok, frees_bad;

    function new();
      set_block_count(16'(NumBlocksDef));
    endfunction

    function int unsigned managed_blocks();
      return (block_count > NumBlocksDef) ? NumBlocksDef : int'(block_count);
    endfunction

    function void set_block_count(logic [15:0] value);
      block_count = value;
      foreach (used_map[i]) used_map[i] = 1'b1;
      used_blocks = managed_blocks();
    endfunction

    function void mismatch(string what, longint unsigned want_v, longint unsigned got_v);
      errors++;
      if (errors <= MaxReports) begin
        $display("[%0t] %s mismatch at result %0d: expected 0x%0h, got 0x%0h",
                 $time, what, checked, want_v, got_v);
      end
    endfunction

    function void note_request(logic kind, logic [AddrW-1:0] addr);
      int unsigned   cnt, blk, in_use;
      alloc_result_t r;
      cnt = managed_blocks();
      r.status = STATUS_OK;
      r.block_address = '0;
      requests++;
      if (kind == KindAlloc) begin
        if (used_blocks < cnt) begin
          blk = 0;
          while (used_map[blk]) blk++;
          used_map[blk] = 1'b1;
          used_blocks++;
          r.block_address = BaddrW'(blk << BlockShiftDef);
          allocs_ok++;
        end else begin
          r.status = STATUS_NONE_FREE;
          none_free++;
        end
      end else begin
        blk = addr >> BlockShiftDef;
        if (blk >= cnt || !used_map[blk] || used_blocks == 0) begin
          r.status = STATUS_BAD_FREE;
          frees_bad++;
        end else begin
          used_map[blk] = 1'b0;
          used_blocks--;
          frees_ok++;
        end
      end
      in_use = (used_blocks > cnt) ? cnt : used_blocks;
      r.free_bytes = FreeW'((cnt - in_use) << BlockShiftDef);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [MDataW-1:0] data);
      alloc_result_t     want;
      logic [BaddrW-1:0] got_addr;
      logic [FreeW-1:0]  got_free;
      got_addr = data[BaddrW-1:0];
      got_free = data[BaddrW+FreeW-1:BaddrW];
      if (pending_results.size() == 0) begin
        mismatch("unexpected result word", 0, data);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (status !== want.status) mismatch("status", want.status, status);
      if (got_addr !== want.block_address) mismatch("block_address", want.block_address, got_addr);
      if (got_free !== want.free_bytes) mismatch("free_bytes", want.free_bytes, got_free);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel, penable, pwrite;
  logic [ApbAw-1:0]    paddr;
  logic [ApbDw-1:0]    pwdata;
  logic [ApbDw-1:0]    prdata;
  logic                pready;
  logic                s_axis_tvalid, s_axis_tready;
  logic [AddrW-1:0]    s_axis_tdata;   // [31:0] address
  logic                s_axis_tuser;   // [0] kind
  logic                m_axis_tvalid, m_axis_tready;
  logic [MDataW-1:0]   m_axis_tdata;   // [26:0] block_address, [54:27] free_bytes
  logic [1:0]          m_axis_tuser;   // [1:0] status

  alloc_scoreboard sb;
  bit              no_gaps;
  bit              long_hold_req;
  int unsigned     alloc_pct;
  int unsigned     idle_cycles;
  int unsigned     settings_used;

  bitmap_page_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired after %0d cycles without a handshake", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned wait_cycles;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 4);
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic write_reg(input logic [ApbAw-1:0] addr, input logic [ApbDw-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == BlockCountAddr) begin
      sb.set_block_count(value[15:0]);
      settings_used++;
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= BlockCountAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== sb.block_count) sb.mismatch("block_count readback", sb.block_count, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_request(input bit draw, input logic kind, input logic [AddrW-1:0] addr);
    int unsigned gap, cnt, pick, blk, tries;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (draw) begin
      cnt  = sb.managed_blocks();
      pick = $urandom_range(0, 99);
      addr = $urandom();
      if (pick < alloc_pct) begin
        kind = KindAlloc;
      end else begin
        kind = KindFree;
        if (cnt > 0 && pick < alloc_pct + (100 - alloc_pct) * 6 / 10) begin
          blk = $urandom_range(0, cnt - 1);
          addr = {blk[19:0], addr[11:0]};
        end else if (cnt > 0 && pick < 90) begin
          blk = $urandom_range(0, cnt - 1);
          tries = 0;
          while (sb.used_map[blk] && tries < 8) begin
            blk = $urandom_range(0, cnt - 1);
            tries++;
          end
          addr = {blk[19:0], addr[11:0]};
        end else if (pick < 95) begin
          blk = $urandom_range(cnt, 20'hFFFFF);
          addr = {blk[19:0], addr[11:0]};
        end
      end
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic run_random(input int unsigned n, input int unsigned pct);
    alloc_pct = pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_request(1'b1, KindAlloc, '0);
    end
    no_gaps = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KindAlloc;
    no_gaps       = 1'b0;
    long_hold_req = 1'b0;
    alloc_pct     = 50;
    idle_cycles   = 0;
    settings_used = 1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(1'b0, KindAlloc, 32'hFFFF_FFFF);
    send_request(1'b0, KindFree,  32'h0000_0000);
    send_request(1'b0, KindFree,  32'h0000_0000);
    send_request(1'b0, KindFree,  32'h07FF_FFFF);
    send_request(1'b0, KindFree,  32'h0800_0000);
    send_request(1'b0, KindFree,  32'hFFFF_FFFF);
    send_request(1'b0, KindFree,  32'h7FFF_F000);
    send_request(1'b0, KindFree,  32'h0000_1ABC);
    send_request(1'b0, KindAlloc, 32'h0000_0000);
    send_request(1'b0, KindAlloc, 32'h5555_5555);
    send_request(1'b0, KindAlloc, 32'hAAAA_AAAA);
    send_request(1'b0, KindAlloc, 32'h0000_0000);
    send_request(1'b0, KindFree,  32'h0000_2000);
    send_request(1'b0, KindFree,  32'h0000_4FFF);
    send_request(1'b0, KindFree,  32'h0000_4000);
    send_request(1'b0, KindAlloc, 32'h0000_0000);
    send_request(1'b0, KindAlloc, 32'h0000_0000);
    send_request(1'b0, KindAlloc, 32'h0000_0000);
    run_random(250, 35);
    run_random(150, 70);
    drain_results();

    write_reg(BlockCountAddr, 32'd40);
    run_random(200, 40);
    drain_results();

    write_reg(BlockCountAddr, 32'd0);
    run_random(30, 50);
    drain_results();

    write_reg(BlockCountAddr, 32'd1);
    run_random(60, 50);
    drain_results();

    write_reg(UnusedRegAddr, 32'hFFFF_FFFF);
    run_random(10, 50);
    drain_results();

    write_reg(BlockCountAddr, 32'h0000_FFFF);
    long_hold_req = 1'b1;
    run_random(120, 40);
    drain_results();
    run_random(130, 40);
    drain_results();

    write_reg(BlockCountAddr, $urandom_range(2, 32767));
    run_random(200, 45);
    drain_results();

    write_reg(BlockCountAddr, 32'd32);
    run_random(100, 40);
    drain_results();

    write_reg(BlockCountAddr, 32'hFFFF_0021);
    run_random(60, 45);
    drain_results();

    if (sb.pending_results.size() != 0) sb.mismatch("outstanding results", 0, sb.pending_results.size());
    $display("Ran %0d requests over %0d block count settings: %0d allocations, %0d with no free block,",
             sb.requests, settings_used, sb.allocs_ok, sb.none_free);
    $display("%0d frees accepted and %0d rejected; %0d results checked, %0d mismatches.",
             sb.frees_ok, sb.frees_bad, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_ffs.sv
rtl/core/bitmap_page_allocator.sv
tb/testbench.sv
